### rtl/ppsm_pkg.sv
// ----------------------------------------------------------------------------
// ppsm_pkg
// Shared types, constants and the control store of the speed meter.
// ----------------------------------------------------------------------------
package ppsm_pkg;

	// field and register widths
	localparam int OP_W     = 2;
	localparam int TIME_W   = 32;
	localparam int PER_W    = 24;
	localparam int GLITCH_W = 20;
	localparam int STALL_W  = 24;
	localparam int WIN_W    = 24;
	localparam int RATE_W   = 20;
	localparam int SUM_W    = 25;  // window plus one period never passes this
	localparam int SCALE_W  = 30;
	localparam int DATA_W   = 32;
	localparam int PADDR_W  = 4;
	localparam int REG_W    = 2;

	// opcodes of the request
	localparam logic [OP_W-1:0] OP_EDGE  = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
	localparam logic [OP_W-1:0] OP_BREAK = 2'd2;

	// register indexes (paddr[3:2])
	localparam logic [REG_W-1:0] REG_GLITCH = 2'd0;
	localparam logic [REG_W-1:0] REG_STALL  = 2'd1;
	localparam logic [REG_W-1:0] REG_WINDOW = 2'd2;

	// register reset values
	localparam logic [GLITCH_W-1:0] GLITCH_RST = 20'd1000;
	localparam logic [STALL_W-1:0]  STALL_RST  = 24'd500000;
	localparam logic [WIN_W-1:0]    WINDOW_RST = 24'd200000;

	// rate arithmetic: periods per microsecond to millihertz
	localparam logic [SCALE_W-1:0] SCALE    = 30'd1000000000;
	localparam logic [RATE_W-1:0]  RATE_MAX = 20'd1000000;

	// micro-program counter
	typedef enum logic [3:0] {
		U_IDLE  = 4'd0,
		U_EDGE  = 4'd1,
		U_BRK   = 4'd2,
		U_QCHK  = 4'd3,
		U_WALK  = 4'd4,
		U_MUL   = 4'd5,
		U_DVST  = 4'd6,
		U_DIV   = 4'd7,
		U_SAT   = 4'd8,
		U_EMIT  = 4'd9
	} upc_t;

	typedef enum logic [3:0] {
		ACT_FETCH,
		ACT_PULSE,
		ACT_BREAK,
		ACT_QCHK,
		ACT_WALK,
		ACT_MUL,
		ACT_DVST,
		ACT_DIV,
		ACT_SAT,
		ACT_EMIT
	} act_t;

	// how the next step is chosen
	typedef enum logic [1:0] {
		SEL_ALWAYS,
		SEL_FLAG,
		SEL_DISPATCH
	} sel_t;

	typedef struct packed {
		act_t act;
		sel_t sel;
		upc_t jmp_hit;   // taken when the step flag is set (or always)
		upc_t jmp_miss;  // taken otherwise
	} ucw_t;

	// datapath enables decoded from the control word
	typedef struct packed {
		logic fetch;
		logic pulse;
		logic brk;
		logic qchk;
		logic walk;
		logic mul;
		logic dvst;
		logic div;
		logic sat;
		logic emit;
	} ctl_t;

	// control store
	function automatic ucw_t ucode(input upc_t pc);
		ucw_t w;
		unique case (pc)
			U_IDLE: w = '{ACT_FETCH, SEL_DISPATCH, U_IDLE, U_IDLE};
			U_EDGE: w = '{ACT_PULSE, SEL_ALWAYS,   U_IDLE, U_IDLE};
			U_BRK:  w = '{ACT_BREAK, SEL_ALWAYS,   U_IDLE, U_IDLE};
			U_QCHK: w = '{ACT_QCHK,  SEL_FLAG,     U_EMIT, U_WALK};
			U_WALK: w = '{ACT_WALK,  SEL_FLAG,     U_WALK, U_MUL};
			U_MUL:  w = '{ACT_MUL,   SEL_FLAG,     U_EMIT, U_DVST};
			U_DVST: w = '{ACT_DVST,  SEL_ALWAYS,   U_DIV,  U_DIV};
			U_DIV:  w = '{ACT_DIV,   SEL_FLAG,     U_DIV,  U_SAT};
			U_SAT:  w = '{ACT_SAT,   SEL_ALWAYS,   U_EMIT, U_EMIT};
			U_EMIT: w = '{ACT_EMIT,  SEL_FLAG,     U_EMIT, U_IDLE};
			default: w = '{ACT_FETCH, SEL_ALWAYS,  U_IDLE, U_IDLE};
		endcase
		return w;
	endfunction

endpackage

### rtl/ppsm_req_if.sv
// ----------------------------------------------------------------------------
// ppsm_req_if
// Request channel: event or query with its microsecond timestamp.
// ----------------------------------------------------------------------------
interface ppsm_req_if;
	import ppsm_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [TIME_W-1:0] time_us;

	modport source (output valid, output op, output time_us, input ready);
	modport sink   (input valid, input op, input time_us, output ready);
endinterface

### rtl/ppsm_rsp_if.sv
// ----------------------------------------------------------------------------
// ppsm_rsp_if
// Result channel: measured rate and its valid flag.
// ----------------------------------------------------------------------------
interface ppsm_rsp_if;
	import ppsm_pkg::*;

	logic              valid;
	logic              ready;
	logic [RATE_W-1:0] speed_mhz;
	logic              speed_valid;

	modport source (output valid, output speed_mhz, output speed_valid, input ready);
	modport sink   (input valid, input speed_mhz, input speed_valid, output ready);
endinterface

### rtl/ppsm_ram.sv
// ----------------------------------------------------------------------------
// ppsm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ppsm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/pulse_period_speed_meter.sv
// ----------------------------------------------------------------------------
// pulse_period_speed_meter
// Tachometer speed measurement by averaging recent pulse periods.
// ----------------------------------------------------------------------------
// Edge events store the time since the previous accepted edge in a ring of
// RING_DEPTH periods; break events store a zero period that fences off older
// history. A query walks back from the newest period until the sum reaches
// average_window_us, a zero entry turns up or the ring runs out, then returns
// n * 1e9 / sum in millihertz, saturated at 1000000. One transaction is
// handled at a time by a micro-programmed sequencer driving a small datapath.
// Edge and break transactions update the ring (an edge also the mark) and go
// straight back to idle. A query walks the ring, then divides in a restoring
// divider DW = clog2(RING_DEPTH+1) + 30 bits wide (39 at the default depth):
// the walk reads one ring entry per cycle from the single RAM read port and
// the divider retires one quotient bit per cycle. A new request is taken
// while a finished result still waits in the output register. The ring
// needs no clearing pass: a fill count marks entries never written since
// reset, which read as zero. Registers sit at byte addresses 0, 4 and 8 of
// the APB port.
// ----------------------------------------------------------------------------
module pulse_period_speed_meter #(
	parameter int RING_DEPTH = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	ppsm_req_if.sink                     req,
	ppsm_rsp_if.source                   rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ppsm_pkg::PADDR_W-1:0] paddr,
	input  logic [ppsm_pkg::DATA_W-1:0]  pwdata,
	output logic [ppsm_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import ppsm_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);       // ring index
	localparam int NW = $clog2(RING_DEPTH + 1);   // period count, holds the depth
	localparam int DW = NW + SCALE_W;             // dividend / quotient
	localparam int CW = $clog2(DW + 1);           // divider step counter

	// --- configuration registers ------------------------------------------
	logic [GLITCH_W-1:0] glitch_q;
	logic [STALL_W-1:0]  stall_q;
	logic [WIN_W-1:0]    window_q;
	logic                cfg_wr;
	logic [REG_W-1:0]    reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glitch_q <= GLITCH_RST;
			stall_q  <= STALL_RST;
			window_q <= WINDOW_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_GLITCH: glitch_q <= pwdata[GLITCH_W-1:0];
				REG_STALL:  stall_q  <= pwdata[STALL_W-1:0];
				REG_WINDOW: window_q <= pwdata[WIN_W-1:0];
				default: ;  // beyond the register map: ignored
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_GLITCH: prdata = DATA_W'(glitch_q);
			REG_STALL:  prdata = DATA_W'(stall_q);
			REG_WINDOW: prdata = DATA_W'(window_q);
			default:    prdata = '0;
		endcase
	end

	// --- sequencer --------------------------------------------------------
	upc_t upc_q, upc_nxt;
	ucw_t ucw;
	ctl_t ctl;
	logic flag;   // condition of the current step, chosen by its action

	assign ucw = ucode(upc_q);

	// next step
	always_comb begin
		unique case (ucw.sel)
			SEL_ALWAYS: upc_nxt = ucw.jmp_hit;
			SEL_FLAG:   upc_nxt = flag ? ucw.jmp_hit : ucw.jmp_miss;
			SEL_DISPATCH: begin
				if (req.valid) begin
					unique case (req.op)
						OP_EDGE:  upc_nxt = U_EDGE;
						OP_QUERY: upc_nxt = U_QCHK;
						OP_BREAK: upc_nxt = U_BRK;
						default:  upc_nxt = U_IDLE;   // unused opcode, no effect
					endcase
				end else begin
					upc_nxt = ucw.jmp_miss;
				end
			end
			default: upc_nxt = U_IDLE;
		endcase
	end

	// step decode
	always_comb begin
		ctl = '0;
		unique case (ucw.act)
			ACT_FETCH: ctl.fetch = 1'b1;
			ACT_PULSE: ctl.pulse = 1'b1;
			ACT_BREAK: ctl.brk   = 1'b1;
			ACT_QCHK:  ctl.qchk  = 1'b1;
			ACT_WALK:  ctl.walk  = 1'b1;
			ACT_MUL:   ctl.mul   = 1'b1;
			ACT_DVST:  ctl.dvst  = 1'b1;
			ACT_DIV:   ctl.div   = 1'b1;
			ACT_SAT:   ctl.sat   = 1'b1;
			ACT_EMIT:  ctl.emit  = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_IDLE;
		end else begin
			upc_q <= upc_nxt;
		end
	end

	assign req.ready = ctl.fetch;

	// --- edge mark and ring -------------------------------------------------
	logic              seen_q;
	logic [TIME_W-1:0] last_q;
	logic [TIME_W-1:0] time_q;
	logic [TIME_W-1:0] diff;
	logic              wrapped, stale, long_enough;
	logic [AW-1:0]     ws_q;
	logic [NW-1:0]     fill_q;
	logic              ram_we;
	logic [PER_W-1:0]  ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [PER_W-1:0]  ram_rdata;
	logic [AW-1:0]     newest;

	assign diff        = time_q - last_q;
	assign wrapped     = time_q < last_q;
	assign stale       = diff > TIME_W'(stall_q);
	assign long_enough = diff > TIME_W'(glitch_q);
	assign newest      = (ws_q == '0) ? AW'(RING_DEPTH - 1) : ws_q - AW'(1);

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = '0;
		if (ctl.pulse && seen_q && !wrapped && !stale && long_enough) begin
			ram_we    = 1'b1;
			ram_wdata = diff[PER_W-1:0];
		end
		if (ctl.brk) begin
			ram_we = 1'b1;   // zero period: break marker
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			last_q <= '0;
			ws_q   <= '0;
			fill_q <= '0;
		end else begin
			if (ctl.pulse) begin
				if (!seen_q) begin
					seen_q <= 1'b1;
					last_q <= time_q;
				end else if (wrapped || stale) begin
					seen_q <= 1'b0;
					last_q <= '0;
				end else if (long_enough) begin
					last_q <= time_q;
				end
			end
			if (ctl.qchk && seen_q && stale) begin
				seen_q <= 1'b0;
				last_q <= '0;
			end
			if (ram_we) begin
				ws_q <= (ws_q == AW'(RING_DEPTH - 1)) ? '0 : ws_q + AW'(1);
				if (fill_q != NW'(RING_DEPTH)) begin
					fill_q <= fill_q + NW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fetch && req.valid) begin
			time_q <= req.time_us;
		end
	end

	ppsm_ram #(
		.WIDTH (PER_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ws_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// --- walk, multiply, divide ----------------------------------------------
	logic [AW-1:0]     ptr_q;
	logic [AW-1:0]     ptr_prev;
	logic [NW-1:0]     n_q;
	logic [SUM_W-1:0]  sum_q;
	logic [PER_W-1:0]  per;
	logic              walk_on;
	logic [DW-1:0]     prod;
	logic [DW-1:0]     prod_q;
	logic [SUM_W-1:0]  rem_q;
	logic [DW-1:0]     quo_q;
	logic [CW-1:0]     cnt_q;
	logic [SUM_W:0]    rem_sh;
	logic              quo_bit;
	logic [RATE_W-1:0] res_mhz_q;
	logic              res_ok_q;
	logic              out_busy;

	assign ptr_prev  = (ptr_q == '0) ? AW'(RING_DEPTH - 1) : ptr_q - AW'(1);
	assign ram_raddr = ctl.qchk ? newest : ptr_prev;

	// entries beyond the fill count were never written and read as zero
	assign per     = (n_q < fill_q) ? ram_rdata : '0;
	assign walk_on = (sum_q < SUM_W'(window_q)) && (n_q < NW'(RING_DEPTH)) && (per != '0);

	assign prod    = DW'(n_q) * DW'(SCALE);
	assign rem_sh  = {rem_q, quo_q[DW-1]};
	assign quo_bit = rem_sh >= {1'b0, sum_q};

	assign out_busy = rsp.valid && !rsp.ready;

	always_comb begin
		flag = 1'b0;
		if (ctl.qchk) flag = !seen_q || stale;
		if (ctl.walk) flag = walk_on;
		if (ctl.mul)  flag = (n_q == '0);
		if (ctl.div)  flag = (cnt_q != CW'(1));
		if (ctl.emit) flag = out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (ctl.qchk) begin
			n_q <= '0;
		end else if (ctl.walk && walk_on) begin
			n_q <= n_q + NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.qchk) begin
			sum_q <= '0;
			ptr_q <= newest;
			if (!seen_q || stale) begin
				res_mhz_q <= '0;
				res_ok_q  <= 1'b0;
			end
		end
		if (ctl.walk && walk_on) begin
			sum_q <= sum_q + SUM_W'(per);
			ptr_q <= ptr_prev;
		end
		if (ctl.mul) begin
			prod_q <= prod;
			if (n_q == '0) begin
				res_mhz_q <= '0;
				res_ok_q  <= 1'b0;
			end
		end
		if (ctl.dvst) begin
			rem_q <= '0;
			quo_q <= prod_q;
			cnt_q <= CW'(DW);
		end
		// restoring division, one quotient bit per step
		if (ctl.div) begin
			rem_q <= quo_bit ? SUM_W'(rem_sh - {1'b0, sum_q}) : rem_sh[SUM_W-1:0];
			quo_q <= {quo_q[DW-2:0], quo_bit};
			cnt_q <= cnt_q - CW'(1);
		end
		if (ctl.sat) begin
			res_mhz_q <= (quo_q > DW'(RATE_MAX)) ? RATE_MAX : quo_q[RATE_W-1:0];
			res_ok_q  <= 1'b1;
		end
	end

	// --- output register ----------------------------------------------------
	logic              out_valid_q;
	logic [RATE_W-1:0] out_mhz_q;
	logic              out_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit && !out_busy) begin
			out_mhz_q <= res_mhz_q;
			out_ok_q  <= res_ok_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.speed_mhz   = out_mhz_q;
	assign rsp.speed_valid = out_ok_q;

	// --- checks ---------------------------------------------------------------
`ifndef NO_ASSERTIONS
	a_ring_write_step: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (upc_q == U_EDGE || upc_q == U_BRK))
		else $error("ring written outside an edge or break step");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= NW'(RING_DEPTH))
		else $error("fill count beyond ring depth");

	a_walk_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= fill_q)
		else $error("walk counted past written entries");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ok_q) |-> (out_mhz_q == '0))
		else $error("invalid result carries a non-zero rate");
`endif

endmodule

### verif/pulse_period_speed_meter_tb.sv
// ----------------------------------------------------------------------------
// pulse_period_speed_meter_tb
// Self-checking bench for the tachometer period-averaging speed meter.
// ----------------------------------------------------------------------------
// A queue of tachometer transactions (edges, queries, break markers and the
// odd unused opcode) is filled by the stimulus process and fed to the request
// channel by a clocked feeder. Every accepted transaction is run through a
// local mirror of the period ring, the edge mark and the registers, which
// yields the expected rate for each query. A clocked checker compares each
// returned rate, field by field, with the oldest expected one. Registers are
// programmed over APB, and read back, only while the meter is idle.
// ----------------------------------------------------------------------------
module pulse_period_speed_meter_tb;
	import ppsm_pkg::*;

	localparam int     RING        = 256;
	localparam int     HOLD_CYCLES = 3000;   // long output hold-off
	localparam int     SETTLE      = 8;      // margin for a last edge or break to finish
	localparam int     TAIL        = 400;    // margin past the longest query
	localparam longint LIMIT_TU    = 64'd10_000_000;

	// opcode the meter must ignore
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [TIME_W-1:0] t;
	} tacho_event_t;

	typedef struct packed {
		logic [RATE_W-1:0] mhz;
		logic              ok;
	} speed_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	ppsm_req_if req ();
	ppsm_rsp_if rsp ();

	pulse_period_speed_meter #(.RING_DEPTH(RING)) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #2 clk = ~clk;

	// pending transactions and expected rates
	tacho_event_t event_backlog [$];
	speed_t       speed_expect_q [$];

	// mirror of the meter: registers, edge mark and period ring
	logic [GLITCH_W-1:0] cfg_glitch;
	logic [STALL_W-1:0]  cfg_stall;
	logic [WIN_W-1:0]    cfg_window;
	logic                mark_ok;
	logic [TIME_W-1:0]   mark_us;
	logic [PER_W-1:0]    period_mirror [RING];
	int                  slot_mirror;

	// traffic shaping
	int src_idle_pct;
	int snk_idle_pct;
	int src_gap;
	int snk_gap;
	int hold_left;
	bit hold_kick;
	bit hold_seen;

	// tallies
	int mismatches;
	int tx_accepted;
	int queries_seen;
	int periods_stored;
	int breaks_stored;
	int rates_checked;
	int rates_valid;
	int rates_saturated;
	int deepest_walk;
	int full_ring_walks;
	int settings_used;

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	function automatic void store_period(input logic [PER_W-1:0] p);
		period_mirror[slot_mirror] = p;
		slot_mirror = (slot_mirror + 1) % RING;
		if (p == '0)
			breaks_stored++;
		else
			periods_stored++;
	endfunction

	// Advance the mirror by one accepted transaction; queries queue a rate.
	function automatic void predict_speed_event(input logic [OP_W-1:0] op,
			input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] gap;
		logic [PER_W-1:0]  p;
		logic [63:0]       sum;
		logic [63:0]       r;
		int                newest;
		int                n;
		speed_t            s;
		gap = t - mark_us;
		s.mhz = '0;
		s.ok = 1'b0;
		case (op)
			OP_EDGE: begin
				if (!mark_ok) begin
					// first edge only sets the mark
					mark_ok = 1'b1;
					mark_us = t;
				end else if (t < mark_us || gap > cfg_stall) begin
					// timer wrap or stall
					mark_ok = 1'b0;
					mark_us = '0;
				end else if (gap > cfg_glitch) begin
					store_period(gap[PER_W-1:0]);
					mark_us = t;
				end
			end
			OP_BREAK: store_period('0);
			OP_QUERY: begin
				queries_seen++;
				if (mark_ok && gap > cfg_stall) begin
					// stale mark: drop it, no rate
					mark_ok = 1'b0;
					mark_us = '0;
				end else if (mark_ok) begin
					newest = (slot_mirror + RING - 1) % RING;
					n = 0;
					sum = '0;
					p = period_mirror[newest];
					while (sum < cfg_window && n < RING && p != '0) begin
						sum += p;
						n++;
						p = period_mirror[(newest + RING - (n % RING)) % RING];
					end
					if (n != 0) begin
						r = (64'(n) * 64'd1_000_000_000) / sum;
						if (r > RATE_MAX) begin
							r = RATE_MAX;
							rates_saturated++;
						end
						s.mhz = r[RATE_W-1:0];
						s.ok = 1'b1;
						rates_valid++;
						if (n > deepest_walk)
							deepest_walk = n;
						if (n == RING)
							full_ring_walks++;
					end
				end
				speed_expect_q.push_back(s);
			end
			default: ;
		endcase
	endfunction

	// Request feeder: holds each transaction until accepted, idles in bursts.
	always @(posedge clk or negedge arst_n) begin : request_feeder
		logic         offer;
		tacho_event_t nxt;
		if (!arst_n) begin
			req.valid <= 1'b0;
			src_gap = 0;
		end else begin
			offer = req.valid;
			if (req.valid && req.ready) begin
				predict_speed_event(req.op, req.time_us);
				tx_accepted++;
				offer = 1'b0;
			end
			if (!offer) begin
				if (src_gap != 0) begin
					src_gap--;
				end else if (event_backlog.size() != 0) begin
					if ($urandom_range(0, 99) < src_idle_pct) begin
						src_gap = $urandom_range(1, 18) - 1;
					end else begin
						nxt = event_backlog.pop_front();
						req.op <= nxt.op;
						req.time_us <= nxt.t;
						offer = 1'b1;
					end
				end
			end
			req.valid <= offer;
		end
	end

	// Long output hold-off, counted here so the checker keeps its own stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_seen <= 1'b0;
		end else if (hold_kick != hold_seen) begin
			hold_seen <= hold_kick;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Rate checker and result-side back-pressure.
	always @(posedge clk or negedge arst_n) begin : speed_checker
		speed_t want;
		logic   take;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			snk_gap = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (speed_expect_q.size() == 0) begin
					report_mismatch($sformatf("unexpected rate %0d (valid %0b)",
						rsp.speed_mhz, rsp.speed_valid));
				end else begin
					want = speed_expect_q.pop_front();
					rates_checked++;
					if (rsp.speed_mhz !== want.mhz)
						report_mismatch($sformatf("rate %0d mHz, expected %0d",
							rsp.speed_mhz, want.mhz));
					if (rsp.speed_valid !== want.ok)
						report_mismatch($sformatf("valid flag %0b, expected %0b",
							rsp.speed_valid, want.ok));
				end
			end
			take = 1'b1;
			if (snk_gap != 0) begin
				snk_gap--;
				take = 1'b0;
			end else if ($urandom_range(0, 99) < snk_idle_pct) begin
				snk_gap = $urandom_range(1, 18) - 1;
				take = 1'b0;
			end
			rsp.ready <= take && (hold_left == 0);
		end
	end

	task automatic enqueue_event(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] t);
		event_backlog.push_back('{op, t});
	endtask

	// Wait until every queued transaction is taken and every rate returned.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (event_backlog.size() != 0 || req.valid || speed_expect_q.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input logic [REG_W-1:0] idx,
			input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Write a register, update the mirror, read it back.
	task automatic set_reg(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] rd;
		logic [DATA_W-1:0] want;
		apb_xfer(1'b1, idx, value, rd);
		case (idx)
			REG_GLITCH: begin
				cfg_glitch = value[GLITCH_W-1:0];
				want = DATA_W'(cfg_glitch);
			end
			REG_STALL: begin
				cfg_stall = value[STALL_W-1:0];
				want = DATA_W'(cfg_stall);
			end
			default: begin
				cfg_window = value[WIN_W-1:0];
				want = DATA_W'(cfg_window);
			end
		endcase
		apb_xfer(1'b0, idx, '0, rd);
		if (rd !== want)
			report_mismatch($sformatf("register %0d reads %0h, expected %0h", idx, rd, want));
		@(negedge clk);
	endtask

	// Drain, then move to a new register setting and traffic shape.
	task automatic new_setting(input logic [DATA_W-1:0] g, input logic [DATA_W-1:0] s,
			input logic [DATA_W-1:0] w, input int src_pct, input int snk_pct);
		wait_idle();
		set_reg(REG_GLITCH, g);
		set_reg(REG_STALL, s);
		set_reg(REG_WINDOW, w);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		settings_used++;
	endtask

	// Queue a pulse train around a nominal period chosen from the current
	// registers. Most transactions are clean edges and queries; noise_pct of
	// them are glitches, stalls, wraps, breaks, jumps and stray opcodes.
	task automatic queue_events(input int count, input int noise_pct, input int query_pct,
			input logic [31:0] span);
		logic [31:0] now;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] nom;
		logic [31:0] per;
		logic [31:0] j;
		lo = 32'(cfg_glitch) + 1;
		hi = (32'(cfg_stall) >= lo) ? 32'(cfg_stall) : lo;
		nom = lo + $urandom_range(0, (hi - lo < span) ? hi - lo : span);
		// some trains start just below the 32-bit wrap
		if ($urandom_range(0, 3) == 0)
			now = 32'hFFFF_FFFF - nom * $urandom_range(0, 200);
		else
			now = $urandom;
		enqueue_event(OP_EDGE, now);
		for (int i = 0; i < count; i++) begin
			j = nom / 8;
			per = nom - j + $urandom_range(0, 2 * j);
			if (per < lo)
				per = lo;
			if (per > hi)
				per = hi;
			if ($urandom_range(0, 99) >= noise_pct) begin
				if ($urandom_range(0, 99) < query_pct) begin
					enqueue_event(OP_QUERY, now + $urandom_range(0, per));
				end else begin
					now += per;
					enqueue_event(OP_EDGE, now);
				end
			end else begin
				case ($urandom_range(0, 7))
					0: enqueue_event(OP_BREAK, now + $urandom_range(0, per));
					1: enqueue_event(OP_EDGE, now + $urandom_range(0, cfg_glitch));
					2: begin
						now += 32'(cfg_stall) + $urandom_range(1, 5000);
						enqueue_event(OP_EDGE, now);
					end
					3: enqueue_event(OP_EDGE, now - $urandom_range(1, per));
					4: begin
						now = $urandom;
						enqueue_event(OP_EDGE, now);
					end
					5: enqueue_event(OP_QUERY, now + 32'(cfg_stall) + $urandom_range(1, 5000));
					6: enqueue_event(OP_UNUSED, $urandom);
					default: enqueue_event(OP_QUERY, $urandom);
				endcase
			end
		end
	endtask

	initial begin : stimulus
		logic [31:0] g;
		logic [31:0] s;
		logic [31:0] w;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.op = OP_EDGE;
		req.time_us = '0;
		rsp.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_kick = 1'b0;
		src_idle_pct = 20;
		snk_idle_pct = 20;
		cfg_glitch = GLITCH_RST;
		cfg_stall = STALL_RST;
		cfg_window = WINDOW_RST;
		mark_ok = 1'b0;
		mark_us = '0;
		slot_mirror = 0;
		for (int i = 0; i < RING; i++)
			period_mirror[i] = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset registers (glitch 1000, stall 500000, window 200000)
		enqueue_event(OP_QUERY, 100);             // no edge seen yet
		enqueue_event(OP_EDGE, 0);                // first edge at time zero
		enqueue_event(OP_QUERY, 5);               // mark but empty ring
		enqueue_event(OP_EDGE, 1000);             // gap equals glitch minimum
		enqueue_event(OP_EDGE, 1001);             // first stored period
		enqueue_event(OP_QUERY, 2000);
		enqueue_event(OP_EDGE, 1500);             // glitch
		enqueue_event(OP_EDGE, 4001);
		enqueue_event(OP_EDGE, 4000);             // time below mark
		enqueue_event(OP_QUERY, 4100);            // mark gone
		enqueue_event(OP_EDGE, 10000);
		enqueue_event(OP_EDGE, 510001);           // gap one over stall
		enqueue_event(OP_EDGE, 600000);
		enqueue_event(OP_EDGE, 1100000);          // gap equals stall, stored
		enqueue_event(OP_QUERY, 1600000);         // query age equals stall
		enqueue_event(OP_QUERY, 1600001);         // stale query
		enqueue_event(OP_EDGE, 2000000);
		enqueue_event(OP_EDGE, 2001200);
		enqueue_event(OP_BREAK, 2001300);
		enqueue_event(OP_QUERY, 2001400);         // newest entry is a break
		enqueue_event(OP_EDGE, 2002400);
		enqueue_event(OP_QUERY, 2002500);         // walk stops at the break
		enqueue_event(OP_UNUSED, 32'hFFFF_FFFF);  // ignored opcode
		enqueue_event(OP_EDGE, 32'hFFFF_F000);    // long gap clears
		enqueue_event(OP_EDGE, 32'hFFFF_F000);
		enqueue_event(OP_EDGE, 32'hFFFF_FFFF);
		enqueue_event(OP_QUERY, 5);               // query age across the wrap
		enqueue_event(OP_QUERY, 32'hFFFF_EFFF);   // query before the mark

		// reset values written back explicitly
		new_setting(GLITCH_RST, STALL_RST, WINDOW_RST, 20, 20);
		queue_events(150, 12, 30, 32'hFFFF_FFFF);

		// widest window and stall, no glitch floor: walks run round the ring
		// and short periods saturate the rate
		new_setting(0, 24'hFF_FFFF, 24'hFF_FFFF, 15, 15);
		queue_events(400, 0, 25, 2000);

		// glitch floor of 1000000, one-period window
		new_setting(1000000, 24'hFF_FFFF, 1, 10, 30);
		queue_events(100, 10, 35, 5000000);

		// stall of one microsecond
		new_setting(0, 1, 3, 30, 10);
		queue_events(70, 15, 35, 0);

		// zero window: no query can average
		new_setting(5, 100000, 0, 0, 0);
		queue_events(30, 10, 40, 3000);

		// random settings
		for (int k = 0; k < 3; k++) begin
			g = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 2000) : $urandom_range(0, 1000000);
			if ($urandom_range(0, 4) != 0)
				s = g + $urandom_range(1, 2000000);
			else
				s = $urandom_range(1, 24'hFF_FFFF);
			if (s > 24'hFF_FFFF)
				s = 24'hFF_FFFF;
			w = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 100000)
				: $urandom_range(1, 24'hFF_FFFF);
			new_setting(g, s, w, 10 * $urandom_range(0, 3), 10 * $urandom_range(0, 3));
			queue_events(100, 10, 30, ($urandom_range(0, 1) != 0) ? 32'd3000 : 32'hFFFF_FFFF);
		end

		// results held back while queries keep coming: the meter must
		// back up and stall its request side
		new_setting(500, 600000, 50000, 0, 0);
		hold_kick = ~hold_kick;
		queue_events(40, 0, 70, 1500);

		// closing stretch with no idling on either side
		new_setting(GLITCH_RST, STALL_RST, WINDOW_RST, 0, 0);
		queue_events(160, 8, 30, 4000);

		wait_idle();
		repeat (TAIL) @(negedge clk);
		if (speed_expect_q.size() != 0)
			report_mismatch($sformatf("%0d rates never returned", speed_expect_q.size()));

		$display("covered %0d transactions over %0d register settings: %0d queries,",
			tx_accepted, settings_used, queries_seen);
		$display("  %0d periods stored, %0d breaks, %0d rates checked, %0d valid,",
			periods_stored, breaks_stored, rates_checked, rates_valid);
		$display("  %0d saturated, deepest walk %0d, %0d full-ring walks",
			rates_saturated, deepest_walk, full_ring_walks);
		if (mismatches == 0)
			$display("pulse_period_speed_meter verification clean");
		else
			$display("pulse_period_speed_meter verification failed");
		$finish;
	end

	// watchdog
	initial begin
		#(LIMIT_TU);
		$display("timeout with %0d transactions pending, %0d rates outstanding",
			event_backlog.size(), speed_expect_q.size());
		$display("pulse_period_speed_meter verification failed");
		$finish;
	end

endmodule
